// ===== hdl/scaw_pkg.sv =====
// ----------------------------------------------------------------------------
// scaw_pkg
// shared types and command codes for the sound command to adpcm writer
// ----------------------------------------------------------------------------
package scaw_pkg;

    localparam logic [15:0] CMD_BANK_0 = 16'h00fc;
    localparam logic [15:0] CMD_BANK_2 = 16'h00fd;
    localparam logic [15:0] CMD_BANK_1 = 16'h00fe;
    localparam logic [15:0] CMD_BANK_3 = 16'h00ff;
    localparam logic [15:0] CMD_PASS   = 16'h0078;
    localparam logic [15:0] CMD_SAMPLE_MIN = 16'h0080;

    localparam logic [7:0] BANK_NUM_0 = 8'd0;
    localparam logic [7:0] BANK_NUM_1 = 8'd1;
    localparam logic [7:0] BANK_NUM_2 = 8'd2;
    localparam logic [7:0] BANK_NUM_3 = 8'd3;

    typedef enum logic
    {
        KIND_CHIP_WRITE = 1'b0,
        KIND_BANK_SEL   = 1'b1
    } out_kind_t;

    typedef struct packed
    {
        out_kind_t  kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    // decoded work for one command: number of results and the results
    typedef struct packed
    {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } decode_t;

endpackage

// ===== hdl/scaw_decode.sv =====
// ----------------------------------------------------------------------------
// scaw_decode
// command decode and pending sample register
// ----------------------------------------------------------------------------
module scaw_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        cmd_word,
    input  logic               low_lane,
    input  logic [3:0]         chan_busy,
    input  logic               fire,
    output scaw_pkg::decode_t  dec
);
    import scaw_pkg::*;

    // only the low byte is ever written out
    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [7:0] pend_byte_reg;
    logic [7:0] pend_byte_next;

    logic [15:0] cmd;
    logic        ch_hit;
    logic [1:0]  ch;

    assign cmd = low_lane ? cmd_word : {8'h00, cmd_word[15:8]};

    always_comb
    begin
        ch_hit = 1'b1;
        ch     = 2'd0;
        priority if (cmd[7]) ch = 2'd3;
        else if (cmd[6])     ch = 2'd2;
        else if (cmd[5])     ch = 2'd1;
        else if (cmd[4])     ch = 2'd0;
        else                 ch_hit = 1'b0;
    end

    always_comb
    begin
        dec             = '0;
        dec.r0.kind     = KIND_CHIP_WRITE;
        dec.r1.kind     = KIND_CHIP_WRITE;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        priority if (cmd == CMD_BANK_0)
        begin
            dec.count = 2'd1;
            dec.r0    = '{KIND_BANK_SEL, BANK_NUM_0, 1'b1};
        end
        else if (cmd == CMD_BANK_2)
        begin
            dec.count = 2'd1;
            dec.r0    = '{KIND_BANK_SEL, BANK_NUM_2, 1'b1};
        end
        else if (cmd == CMD_BANK_1)
        begin
            dec.count = 2'd1;
            dec.r0    = '{KIND_BANK_SEL, BANK_NUM_1, 1'b1};
        end
        else if (cmd == CMD_BANK_3)
        begin
            dec.count = 2'd1;
            dec.r0    = '{KIND_BANK_SEL, BANK_NUM_3, 1'b1};
        end
        else if (cmd == CMD_PASS)
        begin
            dec.count = 2'd1;
            dec.r0    = '{KIND_CHIP_WRITE, cmd[7:0], 1'b1};
        end
        else if (pend_valid_reg)
        begin
            // no channel bit keeps the sample armed
            if (ch_hit)
            begin
                pend_valid_next = 1'b0;
                if (!chan_busy[ch])
                begin
                    dec.count = 2'd2;
                    dec.r0    = '{KIND_CHIP_WRITE, pend_byte_reg, 1'b0};
                    dec.r1    = '{KIND_CHIP_WRITE, cmd[7:0], 1'b1};
                end
            end
        end
        else if (cmd > CMD_SAMPLE_MIN)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = cmd[7:0];
        end
        else
        begin
            // channel off
            dec.count       = 2'd1;
            dec.r0          = '{KIND_CHIP_WRITE, cmd[7:0], 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_byte_reg <= pend_byte_next;
        end
    end

endmodule

// ===== hdl/scaw_out_buf.sv =====
// ----------------------------------------------------------------------------
// scaw_out_buf
// two-slot result buffer in front of the master-side stream
// ----------------------------------------------------------------------------
module scaw_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  scaw_pkg::decode_t  dec,
    input  logic               in_valid,
    output logic               fire,
    output logic               tvalid,
    input  logic               tready,
    output scaw_pkg::result_t  head
);
    import scaw_pkg::*;

    result_t    slot_reg [2];
    result_t    slot_next [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] count_after;
    logic [2:0] count_sum;
    logic       pop;

    assign tvalid      = (count_reg != 2'd0);
    assign head        = slot_reg[0];
    assign pop         = tvalid && tready;
    assign count_after = count_reg - {1'b0, pop};
    assign count_sum   = {1'b0, count_after} + {1'b0, dec.count};
    assign fire        = in_valid && (count_sum <= 3'd2);

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = count_after;
        if (fire)
        begin
            count_next = count_sum[1:0];
            if (dec.count != 2'd0)
            begin
                // results land right after whatever is still queued
                if (count_after == 2'd0)
                begin
                    slot_next[0] = dec.r0;
                    slot_next[1] = dec.r1;
                end
                else
                begin
                    slot_next[1] = dec.r0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_fills: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.count == 2'd2 |=> count_reg == 2'd2)
        else $error("result pair not fully queued");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire && !pop |=> $stable(count_reg))
        else $error("buffer count moved without transaction");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !fire |=> count_reg == $past(count_reg) - 2'd1)
        else $error("pop did not drain one result");
`endif

endmodule

// ===== hdl/sound_command_to_adpcm_writer_core.sv =====
// ----------------------------------------------------------------------------
// sound_command_to_adpcm_writer_core
// turns sound command writes into adpcm chip writes and bank selects
//
// channel   dir  tdata                          tuser     tlast
// s_axis    in   cmd_word[15:0] chan_busy[19:16] low_lane  -
// m_axis    out  out_value[7:0]                 out_kind  out_last
//
// a command is registered on input, decoded from that register and its
// results queued in a two-slot buffer. a new command is taken every cycle
// while results fit in the buffer; a command with two chip writes fills
// both slots. reset clears the armed sample and empties both stages. a
// stall on m_axis backs up into the input register and then drops
// s_axis_tready
// ----------------------------------------------------------------------------
module sound_command_to_adpcm_writer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cmd_word[15:0], chan_busy[19:16], zero pad
    input  logic        s_axis_tuser,   // low_lane
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_value[7:0]
    output logic        m_axis_tuser,   // out_kind
    output logic        m_axis_tlast
);
    import scaw_pkg::*;

    logic        in_valid_reg;
    logic [15:0] cmd_word_reg;
    logic        low_lane_reg;
    logic [3:0]  chan_busy_reg;
    logic        fire;
    logic        accept;
    decode_t     dec;
    result_t     head;

    assign s_axis_tready = !in_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_word_reg  <= s_axis_tdata[15:0];
            chan_busy_reg <= s_axis_tdata[19:16];
            low_lane_reg  <= s_axis_tuser;
        end
    end

    scaw_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word_reg),
        .low_lane  (low_lane_reg),
        .chan_busy (chan_busy_reg),
        .fire      (fire),
        .dec       (dec)
    );

    scaw_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dec      (dec),
        .in_valid (in_valid_reg),
        .fire     (fire),
        .tvalid   (m_axis_tvalid),
        .tready   (m_axis_tready),
        .head     (head)
    );

    assign m_axis_tdata = head.value;
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
